// File: hdl/dhca_pkg.sv
// Package for the detector hit channel aggregator.
// Field widths, result status codes, register indexes, reset values,
// controller state type and the command/status structs. No dependencies.
package dhca_pkg;

  localparam int unsigned MODULE_ID_W = 15;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned RES_W       = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned SLOT_OUT_W  = 10;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned USED_OUT_W  = 11;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd160000;
  localparam logic [RES_W-1:0]  RES_RESET    = 16'd160;

  localparam logic ACTION_START = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LIMIT    = 1'b0,
    CFG_TIME_RESOLUTION = 1'b1
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_STARTED  = 3'd0,
    ST_NOT_KEPT = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_NEW      = 3'd3,
    ST_UPDATED  = 3'd4,
    ST_FULL     = 3'd5
  } result_status_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_FOLD   = 6'b000100,
    S_MAPRD  = 6'b001000,
    S_SLOTRD = 6'b010000,
    S_UPD    = 6'b100000
  } ctrl_state_e;

  typedef struct packed {
    logic in_load;
    logic mul_en;
    logic mod_en;
    logic map_rd_en;
    logic slot_rd_en;
    logic commit_early;
    logic commit_hit;
  } dhca_cmd_t;

  typedef struct packed {
    logic early;
    logic out_free;
  } dhca_status_t;

endpackage

// File: hdl/dhca_ctrl.sv
// Controller state machine of the detector hit channel aggregator.
// Sequences accept, check, fold, map read, slot read and commit. Uses dhca_pkg.
module dhca_ctrl
  import dhca_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dhca_status_t sts_i,
  output dhca_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.mul_en = 1'b1;
        if (sts_i.early) begin
          if (sts_i.out_free) begin
            cmd_o.commit_early = 1'b1;
            state_d            = S_IDLE;
          end
        end else begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd_o.mod_en = 1'b1;
        state_d      = S_MAPRD;
      end
      S_MAPRD: begin
        cmd_o.map_rd_en = 1'b1;
        state_d         = S_SLOTRD;
      end
      S_SLOTRD: begin
        cmd_o.slot_rd_en = 1'b1;
        state_d          = S_UPD;
      end
      S_UPD: begin
        if (sts_i.out_free) begin
          cmd_o.commit_hit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/dhca_datapath.sv
// Datapath of the detector hit channel aggregator: input and config registers,
// module fold, module map and slot memories, update logic, output register.
// Uses dhca_pkg; driven by dhca_ctrl.
module dhca_datapath
  import dhca_pkg::*;
#(
  parameter int unsigned NUM_MODULES = 32768,
  parameter int unsigned MAX_SLOTS   = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhca_cmd_t             cmd_i,
  output dhca_status_t          sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  action_i,
  input  logic [MODULE_ID_W-1:0] module_id_i,
  input  logic [TIME_W-1:0]     hit_time_i,
  input  logic                  from_tube_i,
  input  logic                  keep_i,
  input  logic [TIME_W-1:0]     reference_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic [COUNT_W-1:0]    hit_count_o,
  output logic [TIME_W-1:0]     first_time_o,
  output logic                  time_from_tube_o,
  output logic [USED_OUT_W-1:0] slots_used_o
);

  localparam int unsigned MAP_AW     = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int unsigned SLOT_AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int unsigned FOLD_SHIFT = MODULE_ID_W + MAP_AW;
  localparam int unsigned PROD_W     = 2 * MODULE_ID_W + 2;
  localparam longint unsigned RECIP  =
      ((64'd1 << FOLD_SHIFT) + NUM_MODULES - 1) / NUM_MODULES;

  typedef struct packed {
    logic [MAP_AW-1:0]  owner;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  first_time;
    logic               tube;
  } slot_t;

  // input transaction registers
  logic                   action_q;
  logic [MODULE_ID_W-1:0] module_id_q;
  logic [TIME_W-1:0]      hit_time_q;
  logic                   from_tube_q;
  logic                   keep_q;
  logic [TIME_W-1:0]      reference_time_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      action_q         <= action_i;
      module_id_q      <= module_id_i;
      hit_time_q       <= hit_time_i;
      from_tube_q      <= from_tube_i;
      keep_q           <= keep_i;
      reference_time_q <= reference_time_i;
    end
  end

  // configuration and event state
  logic [TIME_W-1:0] win_q;
  logic [RES_W-1:0]  res_q;
  logic [TIME_W-1:0] ref_q, ref_d;
  logic [CNT_W-1:0]  used_q, used_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WINDOW_RESET;
      res_q  <= RES_RESET;
      ref_q  <= '0;
      used_q <= '0;
    end else begin
      ref_q  <= ref_d;
      used_q <= used_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_WINDOW_LIMIT:    win_q <= cfg_data_i;
          CFG_TIME_RESOLUTION: res_q <= cfg_data_i[RES_W-1:0];
          default:             ;
        endcase
      end
    end
  end

  // early classification
  logic           outside;
  logic           early;
  result_status_e early_status;

  assign outside = (hit_time_q > ref_q) && ((hit_time_q - ref_q) > win_q);

  always_comb begin
    early        = 1'b1;
    early_status = ST_STARTED;
    if (action_q == ACTION_START) begin
      early_status = ST_STARTED;
    end else if (!keep_q) begin
      early_status = ST_NOT_KEPT;
    end else if (outside) begin
      early_status = ST_OUTSIDE;
    end else begin
      early = 1'b0;
    end
  end

  // module fold by reciprocal multiply
  logic [PROD_W-1:0]      prod_q;
  logic [MODULE_ID_W-1:0] quot;
  logic [31:0]            quot_n;
  logic [MAP_AW-1:0]      mod_q;

  assign quot   = MODULE_ID_W'(prod_q >> FOLD_SHIFT);
  assign quot_n = 32'(quot) * 32'(NUM_MODULES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(module_id_q) * PROD_W'(RECIP);
    end
    if (cmd_i.mod_en) begin
      mod_q <= MAP_AW'(32'(module_id_q) - quot_n);
    end
  end

  // memories; map entries are trusted only when the slot owner points back
  logic [SLOT_AW-1:0] map_mem [NUM_MODULES];
  slot_t              slot_mem [MAX_SLOTS];
  logic [SLOT_AW-1:0] map_q;
  slot_t              slot_q;
  logic               map_we, slot_we;
  logic [SLOT_AW-1:0] slot_wa;
  slot_t              slot_wd;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[mod_q] <= slot_wa;
    end
    if (cmd_i.map_rd_en) begin
      map_q <= map_mem[mod_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (cmd_i.slot_rd_en) begin
      slot_q <= slot_mem[map_q];
    end
  end

  // hit update
  logic               lookup_hit;
  logic               table_full;
  logic [TIME_W-1:0]  new_ft;
  logic               new_flag;
  logic [COUNT_W-1:0] new_cnt;
  result_status_e     hit_status;
  logic               hit_new;

  assign lookup_hit = (CNT_W'(map_q) < used_q) && (slot_q.owner == mod_q);
  assign table_full = used_q >= CNT_W'(MAX_SLOTS);

  always_comb begin
    new_ft   = slot_q.first_time;
    new_flag = slot_q.tube;
    if (from_tube_q) begin
      if (slot_q.tube) begin
        if (hit_time_q < slot_q.first_time) begin
          new_ft = hit_time_q;
        end
      end else if ((slot_q.first_time > hit_time_q) &&
                   ((slot_q.first_time - hit_time_q) > TIME_W'(res_q))) begin
        new_ft   = hit_time_q;
        new_flag = 1'b1;
      end
    end else if (hit_time_q < slot_q.first_time) begin
      new_ft   = hit_time_q;
      new_flag = 1'b0;
    end
    new_cnt = (slot_q.count == '1) ? slot_q.count : slot_q.count + 1'b1;
  end

  always_comb begin
    hit_status         = ST_FULL;
    hit_new            = 1'b0;
    slot_wa            = SLOT_AW'(used_q);
    slot_wd.owner      = mod_q;
    slot_wd.count      = COUNT_W'(1);
    slot_wd.first_time = hit_time_q;
    slot_wd.tube       = from_tube_q;
    slot_we            = 1'b0;
    map_we             = 1'b0;
    if (lookup_hit) begin
      hit_status         = ST_UPDATED;
      slot_wa            = map_q;
      slot_wd.count      = new_cnt;
      slot_wd.first_time = new_ft;
      slot_wd.tube       = new_flag;
      slot_we            = cmd_i.commit_hit;
    end else if (table_full) begin
      hit_status = ST_FULL;
    end else begin
      hit_status = ST_NEW;
      hit_new    = 1'b1;
      slot_we    = cmd_i.commit_hit;
      map_we     = cmd_i.commit_hit;
    end
  end

  always_comb begin
    ref_d  = ref_q;
    used_d = used_q;
    if (cmd_i.commit_early && (action_q == ACTION_START)) begin
      ref_d  = reference_time_q;
      used_d = '0;
    end else if (cmd_i.commit_hit && hit_new) begin
      used_d = used_q + 1'b1;
    end
  end

  // output register
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [SLOT_OUT_W-1:0] slot_oq;
  logic [COUNT_W-1:0]    count_oq;
  logic [TIME_W-1:0]     ft_oq;
  logic                  tube_oq;
  logic [USED_OUT_W-1:0] used_oq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_early || cmd_i.commit_hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_early) begin
      status_q <= early_status;
      slot_oq  <= '0;
      count_oq <= '0;
      ft_oq    <= '0;
      tube_oq  <= 1'b0;
      used_oq  <= USED_OUT_W'(used_d);
    end else if (cmd_i.commit_hit) begin
      status_q <= hit_status;
      if (hit_status == ST_FULL) begin
        slot_oq  <= '0;
        count_oq <= '0;
        ft_oq    <= '0;
        tube_oq  <= 1'b0;
      end else begin
        slot_oq  <= SLOT_OUT_W'(slot_wa);
        count_oq <= slot_wd.count;
        ft_oq    <= slot_wd.first_time;
        tube_oq  <= slot_wd.tube;
      end
      used_oq <= USED_OUT_W'(used_d);
    end
  end

  assign sts_o.early    = early;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_o           = slot_oq;
  assign hit_count_o      = count_oq;
  assign first_time_o     = ft_oq;
  assign time_from_tube_o = tube_oq;
  assign slots_used_o     = used_oq;

endmodule

// File: hdl/detector_hit_channel_aggregator_unit.sv
// Top level of the detector hit channel aggregator.
// Instantiates dhca_ctrl and dhca_datapath; uses dhca_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o | action, module_id, hit_time,
//           |           |                         | from_tube, keep, reference_time
//   out     | output    | out_valid_o/out_ready_i | status, slot, hit_count,
//           |           |                         | first_time, time_from_tube, slots_used
//   cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One transaction at a time. Start, dropped and out-of-window items pass through accept
// and check; stored hits pass through accept, check with fold multiply, fold subtract,
// map read, slot read and commit, the slot read taking its address from the map read.
// Start clears nothing in memory: a map entry counts only if its slot is in use and
// the slot's owner names the module, so there is no clearing pass after reset.
// A full output register holds the commit cycle; no input is taken until it frees.
module detector_hit_channel_aggregator_unit
  import dhca_pkg::*;
#(
  parameter int unsigned NUM_MODULES = 32768,
  parameter int unsigned MAX_SLOTS   = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   action_i,
  input  logic [MODULE_ID_W-1:0] module_id_i,
  input  logic [TIME_W-1:0]      hit_time_i,
  input  logic                   from_tube_i,
  input  logic                   keep_i,
  input  logic [TIME_W-1:0]      reference_time_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [SLOT_OUT_W-1:0]  slot_o,
  output logic [COUNT_W-1:0]     hit_count_o,
  output logic [TIME_W-1:0]      first_time_o,
  output logic                   time_from_tube_o,
  output logic [USED_OUT_W-1:0]  slots_used_o
);

  dhca_cmd_t    cmd;
  dhca_status_t sts;

  dhca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dhca_datapath #(
    .NUM_MODULES (NUM_MODULES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .module_id_i      (module_id_i),
    .hit_time_i       (hit_time_i),
    .from_tube_i      (from_tube_i),
    .keep_i           (keep_i),
    .reference_time_i (reference_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .hit_count_o      (hit_count_o),
    .first_time_o     (first_time_o),
    .time_from_tube_o (time_from_tube_o),
    .slots_used_o     (slots_used_o)
  );

endmodule
